// ===== design/positional_array_insert_delete_defines.svh =====
// Assertion macros for the positional array list block.
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PAI_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define PAI_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pai_pkg.sv =====
// Types and constants shared by the positional array list block.
package pai_pkg;

	localparam int unsigned PAI_CAPACITY = 128;
	localparam int unsigned PAI_GROUP    = 16;

	typedef enum logic [2:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_INS_AT    = 3'd2,
		FN_DEL_FRONT = 3'd3,
		FN_DEL_BACK  = 3'd4,
		FN_DEL_AT    = 3'd5,
		FN_READ_AT   = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_OPEN  = 2'd1,
		CELL_CLOSE = 2'd2
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_FIN  = 2'd2
	} state_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  pos;
		logic [31:0] value;
		logic        rd_en;
	} cell_cmd_t;

endpackage

// ===== design/pai_in_if.sv =====
// Request channel: valid/ready plus the request fields.
interface pai_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic [7:0]         position;

	modport source (output valid, func, value, position, input ready);
	modport sink (input valid, func, value, position, output ready);
endinterface

// ===== design/pai_out_if.sv =====
// Response channel: valid/ready plus the result fields.
interface pai_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [7:0]         count_after;

	modport source (output valid, status, read_value, count_after, input ready);
	modport sink (input valid, status, read_value, count_after, output ready);
endinterface

// ===== design/positional_array_insert_delete.sv =====
// Top level of the positional array list: control, cell row and read tree.
//
// Usage:
//   req  : request beats (func, value, position), valid/ready.
//   rsp  : one response beat per request (status, read_value, count_after).
//   The list lives in a row of CAPACITY cells; inserts and non-back deletes
//   shift the cells from the position onward at once, one neighbor step each.
// Sequence:
//   An accepted request is captured, then executes in the execute state, and
//   its response is loaded into the output register (valid from then on).
//   req.ready is high only in the idle state, so a new request is taken only
//   once the last one has left the final step; the three steps are accept,
//   shift in the cells with read-group capture, and the final OR across groups.
// Stall:
//   The next request is taken while a response still waits; it then holds
//   in the final step until the output register is free. Nothing is lost.
// Reset:
//   arst_n clears the count, the control state and the response valid.
//   Cell contents are not reset; entries at or beyond the count are never
//   read, so their content does not matter.
module positional_array_insert_delete import pai_pkg::*; #(
	parameter int unsigned CAPACITY = PAI_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	pai_in_if.sink     req,
	pai_out_if.source  rsp
);

`include "positional_array_insert_delete_defines.svh"

	localparam int unsigned NGROUPS = (CAPACITY + PAI_GROUP - 1) / PAI_GROUP;
	localparam logic [7:0]  CAP8    = 8'(CAPACITY);

	// control
	state_t state_q, state_nxt;
	logic   exec_en, fin_load, take;

	// request capture
	logic [2:0]  req_func_q;
	logic [31:0] req_val_q;
	logic [7:0]  req_pos_q;

	// list state
	logic [7:0] count_q, count_nxt;
	status_t    status_c, status_s1;
	cell_cmd_t  cmd;

	// cell row and read tree
	logic [CAPACITY-1:0][31:0]        cell_data;
	logic [CAPACITY-1:0][31:0]        cell_rd;
	logic [NGROUPS*PAI_GROUP-1:0][31:0] rd_pad;
	logic [NGROUPS-1:0][31:0]         grp_s1;
	logic [31:0]                      rd_c;

	// response register
	logic        rsp_valid_q;
	status_t     rsp_status_q;
	logic [31:0] rsp_rdata_q;
	logic [7:0]  rsp_count_q;

	assign take = req.valid && req.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (req.valid) state_nxt = S_EXEC;
			S_EXEC: state_nxt = S_FIN;
			S_FIN:  if (!rsp_valid_q || rsp.ready) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = 1'b0;
		exec_en   = 1'b0;
		fin_load  = 1'b0;
		case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_EXEC: exec_en = 1'b1;
			S_FIN:  fin_load = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_func_q <= req.func;
			req_val_q  <= req.value;
			req_pos_q  <= req.position;
		end
	end

	// Decode: status, cell command and new count. Full is checked before
	// position on inserts, empty before position on deletes and reads.
	always_comb begin
		status_c   = ST_OK;
		count_nxt  = count_q;
		cmd.op     = CELL_HOLD;
		cmd.pos    = req_pos_q;
		cmd.value  = req_val_q;
		cmd.rd_en  = 1'b0;
		if (exec_en) begin
			case (req_func_q)
				FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
					if (count_q >= CAP8) begin
						status_c = ST_FULL;
					end else if (req_func_q == FN_INS_AT && req_pos_q > count_q) begin
						status_c = ST_BADPOS;
					end else begin
						cmd.op    = CELL_OPEN;
						count_nxt = count_q + 8'd1;
						if (req_func_q == FN_INS_FRONT) begin
							cmd.pos = '0;
						end else if (req_func_q == FN_INS_BACK) begin
							cmd.pos = count_q;
						end
					end
				end
				FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
					if (count_q == '0) begin
						status_c = ST_EMPTY;
					end else if (req_func_q == FN_DEL_AT && req_pos_q >= count_q) begin
						status_c = ST_BADPOS;
					end else begin
						count_nxt = count_q - 8'd1;
						// back delete only drops the count
						if (req_func_q == FN_DEL_FRONT) begin
							cmd.op  = CELL_CLOSE;
							cmd.pos = '0;
						end else if (req_func_q == FN_DEL_AT) begin
							cmd.op = CELL_CLOSE;
						end
					end
				end
				FN_READ_AT: begin
					if (count_q == '0) begin
						status_c = ST_EMPTY;
					end else if (req_pos_q >= count_q) begin
						status_c = ST_BADPOS;
					end else begin
						cmd.rd_en = 1'b1;
					end
				end
				default: status_c = ST_BADPOS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec_en) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			status_s1 <= status_c;
		end
	end

	// cell row: each cell sees its left and right neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		pai_cell #(
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	// pad the read outputs to whole groups
	for (genvar i = 0; i < NGROUPS * PAI_GROUP; i++) begin : g_pad
		if (i < CAPACITY) begin : g_real
			assign rd_pad[i] = cell_rd[i];
		end else begin : g_zero
			assign rd_pad[i] = '0;
		end
	end

	for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
		pai_rdgrp u_grp (
			.clk   (clk),
			.en    (exec_en),
			.words (rd_pad[g*PAI_GROUP +: PAI_GROUP]),
			.or_s1 (grp_s1[g])
		);
	end

	// second level of the read tree; zero unless a read succeeded
	always_comb begin
		rd_c = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			rd_c = rd_c | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			rsp_status_q <= status_s1;
			rsp_rdata_q  <= rd_c;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_rdata_q;
	assign rsp.count_after = rsp_count_q;

	// checks
	`PAI_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CAP8, "count above capacity")
	`PAI_ASSERT_NEXT(a_take_exec, take, state_q == S_EXEC, "accepted beat not executed")
	`PAI_ASSERT_NEXT(a_count_hold, !exec_en, $stable(count_q), "count moved outside execute")
	`PAI_ASSERT_NOW(a_rdata_ok, rsp.valid && rsp.read_value != '0, rsp.status == ST_OK,
		"read value on failed request")

endmodule

// ===== design/pai_cell.sv =====
// One list cell: holds an entry, shifts from a neighbor on open or close, loads the value at the open position.
module pai_cell import pai_pkg::*; #(
	parameter int unsigned INDEX = 0
) (
	input  logic        clk,
	input  cell_cmd_t   cmd,
	input  logic [31:0] left,
	input  logic [31:0] right,
	output logic [31:0] data,
	output logic [31:0] rd_data
);

	localparam logic [7:0] IDX = 8'(INDEX);

	logic [31:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_OPEN: begin
				if (IDX == cmd.pos) begin
					data_q <= cmd.value;
				end else if (IDX > cmd.pos) begin
					data_q <= left;
				end
			end
			CELL_CLOSE: begin
				if (IDX >= cmd.pos) begin
					data_q <= right;
				end
			end
			default: ;
		endcase
	end

	assign data    = data_q;
	// only the addressed cell contributes to the read tree
	assign rd_data = (cmd.rd_en && (IDX == cmd.pos)) ? data_q : '0;

endmodule

// ===== design/pai_rdgrp.sv =====
// Registered OR over one group of cell read outputs, captured on execute.
module pai_rdgrp import pai_pkg::*; (
	input  logic                          clk,
	input  logic                          en,
	input  logic [PAI_GROUP-1:0][31:0]    words,
	output logic [31:0]                   or_s1
);

	logic [31:0] or_c;

	always_comb begin
		or_c = '0;
		for (int i = 0; i < PAI_GROUP; i++) begin
			or_c = or_c | words[i];
		end
	end

	// hold the group result until the next execute so a stalled response keeps it
	always_ff @(posedge clk) begin
		if (en) begin
			or_s1 <= or_c;
		end
	end

endmodule
